### rtl/pwra_pkg.sv
// pwra_pkg: shared types, register indexes, reset values and zone codes
// for the pulse width range averager. Used by every module in rtl/.
`default_nettype none

package pwra_pkg;

   // field and register widths
   localparam int TIMEOUT_W = 20;
   localparam int WIDTH_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;
   localparam int SUM_W     = 16;
   localparam int ZONE_W    = 2;

   // defaults for the top-level parameters
   localparam int DEF_READINGS_PER_BATCH = 10;
   localparam int DEF_TICKS_PER_CM       = 10;

   // reading queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FAR       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MID       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR      = 3'd5;

   // reset values
   localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT   = 20'd1000000;
   localparam logic [WIDTH_W-1:0]   RST_MAX_WIDTH = 16'd4000;
   localparam logic [WIDTH_W-1:0]   RST_GAP       = 16'd2000;
   localparam logic [SUM_W-1:0]     RST_FAR       = 16'd1000;
   localparam logic [SUM_W-1:0]     RST_MID       = 16'd500;
   localparam logic [SUM_W-1:0]     RST_NEAR      = 16'd250;

   // zone codes
   localparam logic [ZONE_W-1:0] ZONE_CLEAR  = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_LONG   = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_MEDIUM = 2'd2;
   localparam logic [ZONE_W-1:0] ZONE_SHORT  = 2'd3;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_us;
      logic [WIDTH_W-1:0]   max_width_us;
      logic [WIDTH_W-1:0]   gap_us;
      logic [SUM_W-1:0]     far_limit;
      logic [SUM_W-1:0]     mid_limit;
      logic [SUM_W-1:0]     near_limit;
   } cfg_type;

   // one finished reading: zero flag set for timeout or over-long pulse
   typedef struct packed {
      logic               zero;
      logic [WIDTH_W-1:0] width;
   } reading_type;

endpackage

`default_nettype wire

### rtl/pwra_front.sv
// pwra_front: per-tick pulse sequencer (wait, high, gap) that classifies
// each finished reading and pushes it to the queue. Depends on pwra_pkg.
`default_nettype none

module pwra_front
   import pwra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        tick_fire,
   input  wire logic        pin_level,
   output logic             push_valid,
   output reading_type      push_data
);

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic [TIMEOUT_W-1:0] high_ff, high_in;

   logic [TIMEOUT_W:0]   elapsed_inc;
   logic [TIMEOUT_W-1:0] high_base;
   logic                 finish;
   logic                 over_width;
   logic [1:0]           phase_done;

   assign elapsed_inc = {1'b0, elapsed_ff} + {{TIMEOUT_W{1'b0}}, 1'b1};
   assign over_width  = high_ff >= {{(TIMEOUT_W-WIDTH_W){1'b0}}, cfg.max_width_us};
   assign phase_done  = (cfg.gap_us == '0) ? PH_WAIT : PH_GAP;

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      high_in    = high_ff;
      finish     = 1'b0;
      push_data.zero  = 1'b1;
      push_data.width = high_ff[WIDTH_W-1:0];
      high_base  = (phase_ff == PH_HIGH) ? high_ff : '0;
      unique case (phase_ff)
         PH_GAP: begin
            if (elapsed_inc >= {{(TIMEOUT_W-WIDTH_W+1){1'b0}}, cfg.gap_us}) begin
               phase_in   = PH_WAIT;
               elapsed_in = '0;
            end else begin
               elapsed_in = elapsed_inc[TIMEOUT_W-1:0];
            end
         end
         default: begin
            if (phase_ff == PH_HIGH && !pin_level) begin
               // falling edge ends the reading, no timeout check
               finish         = 1'b1;
               push_data.zero = over_width;
            end else if (elapsed_inc > {1'b0, cfg.timeout_us}) begin
               finish = 1'b1;
            end else begin
               elapsed_in = elapsed_inc[TIMEOUT_W-1:0];
               if (pin_level) begin
                  high_in  = high_base + {{(TIMEOUT_W-1){1'b0}}, 1'b1};
                  phase_in = PH_HIGH;
               end else begin
                  high_in  = high_base;
                  phase_in = (phase_ff == PH_HIGH) ? PH_HIGH : PH_WAIT;
               end
            end
            if (finish) begin
               high_in    = '0;
               elapsed_in = '0;
               phase_in   = phase_done;
            end
         end
      endcase
   end

   assign push_valid = tick_fire && finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         elapsed_ff <= '0;
         high_ff    <= '0;
      end else if (tick_fire) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         high_ff    <= high_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pwra_queue.sv
// pwra_queue: short first-in first-out queue of finished readings between
// the front sequencer and the back accumulator. Depends on pwra_pkg.
`default_nettype none

module pwra_queue
   import pwra_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire reading_type  push_data,
   input  wire logic         pop,
   output reading_type       pop_data,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   reading_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + {{(PTR_W-1){1'b0}}, 1'b1} : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + {{(PTR_W-1){1'b0}}, 1'b1} : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (pop && !push) begin
         count_in = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pwra_back.sv
// pwra_back: converts readings to centimetres (reciprocal multiply), sums
// a batch with saturation and holds the result beat. Depends on pwra_pkg.
`default_nettype none

module pwra_back
   import pwra_pkg::*;
#(
   parameter int READINGS_PER_BATCH = DEF_READINGS_PER_BATCH,
   parameter int TICKS_PER_CM       = DEF_TICKS_PER_CM
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         queue_empty,
   input  wire reading_type  queue_data,
   output logic              queue_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [SUM_W-1:0]  rsp_average_tenths_cm,
   output logic [ZONE_W-1:0] rsp_zone,
   output logic              rsp_buzz_request
);

   // floor(x / d) == (x * ceil(2^k / d)) >> k for 16-bit x when k = 16 + clog2(d)
   localparam int DIV_SHIFT = WIDTH_W + $clog2(TICKS_PER_CM);
   localparam int MUL_W     = DIV_SHIFT + 1;
   localparam int PROD_W    = WIDTH_W + MUL_W;
   localparam logic [MUL_W-1:0] DIV_MUL =
      MUL_W'(((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));
   localparam int IDX_W = (READINGS_PER_BATCH > 1) ? $clog2(READINGS_PER_BATCH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READINGS_PER_BATCH - 1);

   logic              mul_valid_ff, mul_valid_in;
   logic              mul_zero_ff;
   logic [PROD_W-1:0] mul_prod_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]  out_sum_ff;

   logic              is_last;
   logic              acc_fire;
   logic              mul_ready;
   logic [SUM_W-1:0]  reading_cm;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;

   assign is_last   = (idx_ff == LAST_IDX);
   assign acc_fire  = mul_valid_ff && !(is_last && out_valid_ff && rsp_stall);
   assign mul_ready = !mul_valid_ff || acc_fire;
   assign queue_pop = mul_ready && !queue_empty;

   assign reading_cm = mul_zero_ff ? '0 : mul_prod_ff[DIV_SHIFT +: SUM_W];
   assign sum_wide   = {1'b0, sum_ff} + {1'b0, reading_cm};
   assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   always_comb begin
      mul_valid_in = queue_pop ? 1'b1 : (acc_fire ? 1'b0 : mul_valid_ff);
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (acc_fire) begin
         if (is_last) begin
            idx_in       = '0;
            sum_in       = '0;
            out_valid_in = 1'b1;
         end else begin
            idx_in = idx_ff + {{(IDX_W-1){1'b0}}, 1'b1};
            sum_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         mul_zero_ff <= queue_data.zero;
         mul_prod_ff <= {{MUL_W{1'b0}}, queue_data.width} * {{WIDTH_W{1'b0}}, DIV_MUL};
      end
      if (acc_fire && is_last) begin
         out_sum_ff <= sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // zone follows the held sum; limits must only change while idle, which the block does not enforce
   always_comb begin
      if (out_sum_ff > cfg.far_limit) begin
         rsp_zone = ZONE_CLEAR;
      end else if (out_sum_ff > cfg.mid_limit) begin
         rsp_zone = ZONE_LONG;
      end else if (out_sum_ff > cfg.near_limit) begin
         rsp_zone = ZONE_MEDIUM;
      end else begin
         rsp_zone = ZONE_SHORT;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_average_tenths_cm = out_sum_ff;
   assign rsp_buzz_request      = (rsp_zone == ZONE_MEDIUM) || (rsp_zone == ZONE_SHORT);

endmodule

`default_nettype wire

### rtl/pulse_width_range_averager.sv
// pulse_width_range_averager: top level with csr registers, front sequencer,
// reading queue and back accumulator. Depends on pwra_pkg and pwra_* modules.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | req_pin_level
//   rsp     | out | rsp_valid/stall    | rsp_average_tenths_cm, rsp_zone, rsp_buzz_request
//   csr     | in  | csr_write_en       | csr_index, csr_write_data
//
// one req beat (one microsecond tick) per cycle while req_stall is low; the front
// sequencer updates its phase counters in the cycle the beat is taken.
// a result passes the queue stage, the reciprocal multiply and the accumulate into the
// output register after the tick that ends the last reading of a batch.
// req_stall rises only when the reading queue is full, which happens while the
// rsp side stalls a finished batch and readings keep ending.
// synchronous reset clears the sequencer, queue, batch sum and output valid and
// loads the register defaults.
`default_nettype none

module pulse_width_range_averager
   import pwra_pkg::*;
#(
   parameter int READINGS_PER_BATCH = DEF_READINGS_PER_BATCH,
   parameter int TICKS_PER_CM       = DEF_TICKS_PER_CM
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_pin_level,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [SUM_W-1:0]          rsp_average_tenths_cm,
   output logic [ZONE_W-1:0]         rsp_zone,
   output logic                      rsp_buzz_request,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        tick_fire;
   logic        push_valid;
   reading_type push_data;
   logic        queue_pop;
   reading_type queue_data;
   logic        queue_empty;
   logic        queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_TIMEOUT:   cfg_in.timeout_us   = csr_write_data[TIMEOUT_W-1:0];
            REG_MAX_WIDTH: cfg_in.max_width_us = csr_write_data[WIDTH_W-1:0];
            REG_GAP:       cfg_in.gap_us       = csr_write_data[WIDTH_W-1:0];
            REG_FAR:       cfg_in.far_limit    = csr_write_data[SUM_W-1:0];
            REG_MID:       cfg_in.mid_limit    = csr_write_data[SUM_W-1:0];
            REG_NEAR:      cfg_in.near_limit   = csr_write_data[SUM_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us   <= RST_TIMEOUT;
         cfg_ff.max_width_us <= RST_MAX_WIDTH;
         cfg_ff.gap_us       <= RST_GAP;
         cfg_ff.far_limit    <= RST_FAR;
         cfg_ff.mid_limit    <= RST_MID;
         cfg_ff.near_limit   <= RST_NEAR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;
   assign tick_fire = req_valid && !req_stall;

   pwra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_fire  (tick_fire),
      .pin_level  (req_pin_level),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   pwra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   pwra_back #(
      .READINGS_PER_BATCH (READINGS_PER_BATCH),
      .TICKS_PER_CM       (TICKS_PER_CM)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .queue_empty           (queue_empty),
      .queue_data            (queue_data),
      .queue_pop             (queue_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_average_tenths_cm (rsp_average_tenths_cm),
      .rsp_zone              (rsp_zone),
      .rsp_buzz_request      (rsp_buzz_request)
   );

endmodule

`default_nettype wire
